### rtl/core/rcgs_pkg.sv
// ----------------------------------------------------------------------------
// rcgs_pkg
// Shared constants and types of the capture group scanner.
// ----------------------------------------------------------------------------
package rcgs_pkg;

  // Field widths of the stream beats
  localparam int unsigned CH_W        = 8;
  localparam int unsigned CAP_BEGIN_W = 12;
  localparam int unsigned CAP_END_W   = 13;

  // Default limits
  localparam int unsigned DEFAULT_MAX_DEPTH = 16;
  localparam int unsigned DEFAULT_MAX_LEN   = 4096;

  // Pattern characters of interest
  localparam logic [CH_W-1:0] CH_Q         = 8'h51;  // 'Q'
  localparam logic [CH_W-1:0] CH_E         = 8'h45;  // 'E'
  localparam logic [CH_W-1:0] CH_STAR      = 8'h2A;  // '*'
  localparam logic [CH_W-1:0] CH_QMARK     = 8'h3F;  // '?'
  localparam logic [CH_W-1:0] CH_LT        = 8'h3C;  // '<'
  localparam logic [CH_W-1:0] CH_P         = 8'h50;  // 'P'
  localparam logic [CH_W-1:0] CH_APOS      = 8'h27;  // single quote
  localparam logic [CH_W-1:0] CH_BSLASH    = 8'h5C;  // backslash
  localparam logic [CH_W-1:0] CH_LBRACKET  = 8'h5B;  // '['
  localparam logic [CH_W-1:0] CH_RBRACKET  = 8'h5D;  // ']'
  localparam logic [CH_W-1:0] CH_LPAREN    = 8'h28;  // '('
  localparam logic [CH_W-1:0] CH_RPAREN    = 8'h29;  // ')'

  // Parenthesis events decoded by the mode tracker
  typedef struct packed {
    logic open_grp;
    logic close_grp;
  } ev_t;

  // Status of the group stack for the current character
  typedef struct packed {
    logic found;
    logic push_full;
  } stk_res_t;

endpackage

### rtl/core/rcgs_if.sv
// ----------------------------------------------------------------------------
// rcgs_if
// Valid/ready stream interfaces for pattern characters and scan results.
// ----------------------------------------------------------------------------
interface rcgs_in_if;
  logic                          valid;
  logic                          ready;
  logic [rcgs_pkg::CH_W-1:0]     ch;
  logic                          pattern_start;

  modport source (output valid, ch, pattern_start, input ready);
  modport sink   (input valid, ch, pattern_start, output ready);
endinterface

interface rcgs_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [rcgs_pkg::CAP_BEGIN_W-1:0]   cap_begin;
  logic [rcgs_pkg::CAP_END_W-1:0]     cap_end;
  logic                               overflow;

  modport source (output valid, found, cap_begin, cap_end, overflow, input ready);
  modport sink   (input valid, found, cap_begin, cap_end, overflow, output ready);
endinterface

### rtl/core/rcgs_mode_tracker.sv
// ----------------------------------------------------------------------------
// rcgs_mode_tracker
// Bracket, escape and quoted-literal mode flags; decodes live parentheses.
// ----------------------------------------------------------------------------
module rcgs_mode_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          restart_i,
  input  logic [rcgs_pkg::CH_W-1:0]     ch_i,
  output rcgs_pkg::ev_t                 ev_o
);

  logic bracket_q, bracket_d;
  logic escape_q, escape_d;
  logic literal_q, literal_d;
  logic lit_bs_q, lit_bs_d;
  logic bracket_c, escape_c, literal_c, lit_bs_c;

  always_comb begin
    // a new pattern starts from cleared flags
    bracket_c = restart_i ? 1'b0 : bracket_q;
    escape_c  = restart_i ? 1'b0 : escape_q;
    literal_c = restart_i ? 1'b0 : literal_q;
    lit_bs_c  = restart_i ? 1'b0 : lit_bs_q;

    bracket_d = bracket_c;
    escape_d  = escape_c;
    literal_d = literal_c;
    lit_bs_d  = lit_bs_c;
    ev_o      = '0;

    if (bracket_c) begin
      if (ch_i == rcgs_pkg::CH_RBRACKET) bracket_d = 1'b0;
    end else if (escape_c) begin
      escape_d = 1'b0;
      if (ch_i == rcgs_pkg::CH_Q) literal_d = 1'b1;
    end else if (literal_c) begin
      if (lit_bs_c && ch_i == rcgs_pkg::CH_E) begin
        lit_bs_d  = 1'b0;
        literal_d = 1'b0;
      end else begin
        lit_bs_d = (ch_i == rcgs_pkg::CH_BSLASH);
      end
    end else if (ch_i == rcgs_pkg::CH_BSLASH) begin
      escape_d = 1'b1;
    end else if (ch_i == rcgs_pkg::CH_LBRACKET) begin
      bracket_d = 1'b1;
    end else if (ch_i == rcgs_pkg::CH_LPAREN) begin
      ev_o.open_grp = 1'b1;
    end else if (ch_i == rcgs_pkg::CH_RPAREN) begin
      ev_o.close_grp = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bracket_q <= 1'b0;
      escape_q  <= 1'b0;
      literal_q <= 1'b0;
      lit_bs_q  <= 1'b0;
    end else if (step_i) begin
      bracket_q <= bracket_d;
      escape_q  <= escape_d;
      literal_q <= literal_d;
      lit_bs_q  <= lit_bs_d;
    end
  end

endmodule

### rtl/core/rcgs_group_stack.sv
// ----------------------------------------------------------------------------
// rcgs_group_stack
// Stack of open groups as parallel lanes; each lane collects its first
// three characters and the top lane is classified on a close.
// ----------------------------------------------------------------------------
module rcgs_group_stack #(
  parameter int unsigned MAX_DEPTH = rcgs_pkg::DEFAULT_MAX_DEPTH,
  parameter int unsigned BegW      = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          restart_i,
  input  logic [rcgs_pkg::CH_W-1:0]     ch_i,
  input  rcgs_pkg::ev_t                 ev_i,
  input  logic [BegW-1:0]               pos_i,
  output rcgs_pkg::stk_res_t            res_o,
  output logic [BegW-1:0]               cap_begin_o
);

  localparam int unsigned CntW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IdxW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned ChW  = rcgs_pkg::CH_W;

  logic [BegW-1:0] beg_q  [MAX_DEPTH];
  logic [BegW-1:0] beg_d  [MAX_DEPTH];
  logic [ChW-1:0]  byte_q [MAX_DEPTH][3];
  logic [ChW-1:0]  byte_d [MAX_DEPTH][3];
  logic [1:0]      nb_q   [MAX_DEPTH];
  logic [1:0]      nb_d   [MAX_DEPTH];
  logic [CntW-1:0] cnt_q, cnt_d, cnt_c;
  logic [IdxW-1:0] top_idx, push_idx;
  logic [ChW-1:0]  b0, b1, b2;
  logic [1:0]      top_nb;
  logic            capturing;

  always_comb begin
    cnt_c    = restart_i ? '0 : cnt_q;
    cnt_d    = cnt_c;
    top_idx  = IdxW'(cnt_c - CntW'(1));
    push_idx = IdxW'(cnt_c);
    res_o    = '0;

    // append the character to every open lane still short of three
    for (int i = 0; i < MAX_DEPTH; i++) begin
      beg_d[i]  = beg_q[i];
      byte_d[i] = byte_q[i];
      nb_d[i]   = nb_q[i];
      if (CntW'(i) < cnt_c && nb_q[i] != 2'd3) begin
        byte_d[i][nb_q[i]] = ch_i;
        nb_d[i]            = nb_q[i] + 2'd1;
      end
    end

    // classify the top lane with the character just appended
    top_nb = nb_d[top_idx];
    b0 = (top_nb > 2'd0) ? byte_d[top_idx][0] : '0;
    b1 = (top_nb > 2'd1) ? byte_d[top_idx][1] : '0;
    b2 = (top_nb > 2'd2) ? byte_d[top_idx][2] : '0;
    if (b0 == rcgs_pkg::CH_QMARK) begin
      capturing = (b1 == rcgs_pkg::CH_LT) || (b1 == rcgs_pkg::CH_APOS) ||
                  (b1 == rcgs_pkg::CH_P && b2 == rcgs_pkg::CH_LT);
    end else begin
      capturing = (b0 != rcgs_pkg::CH_STAR);
    end
    cap_begin_o = beg_q[top_idx];

    if (ev_i.open_grp) begin
      if (cnt_c == CntW'(MAX_DEPTH)) begin
        res_o.push_full = 1'b1;
      end else begin
        beg_d[push_idx] = pos_i;
        nb_d[push_idx]  = 2'd0;
        cnt_d           = cnt_c + CntW'(1);
      end
    end else if (ev_i.close_grp && cnt_c != '0) begin
      res_o.found = capturing;
      cnt_d       = cnt_c - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  // lane contents are only read below the count: no reset needed
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      beg_q  <= beg_d;
      byte_q <= byte_d;
      nb_q   <= nb_d;
    end
  end

endmodule

### rtl/core/regex_capture_group_scanner_top.sv
// ----------------------------------------------------------------------------
// regex_capture_group_scanner_top
// Finds capturing groups in a regular-expression pattern fed byte by byte.
// ----------------------------------------------------------------------------
// Feed the pattern one byte per input beat, with pattern_start set on its
// first byte; every input beat yields exactly one result beat. A result has
// found set when that byte was a ')' that closed a capturing group, with
// cap_begin the position of the matching '(' and cap_end the position just
// past the ')'. Groups opening with '*' or '?' do not capture, except the
// named forms "?<", "?'" and "?P<". Bracket classes, backslash escapes and
// \Q..\E literal runs hide parentheses. Overflow is sticky until the next
// pattern start and flags a '(' beyond MAX_DEPTH open groups (dropped) or a
// byte at position MAX_LEN or later (ignored). The block takes one byte
// every cycle while the output is taken; a byte's result is on the output
// once the byte has passed an input register and then the result register.
// The whole update of mode flags and the stack lanes is combinational
// logic, so back-to-back bytes stream at full rate while the output is
// taken.
// ----------------------------------------------------------------------------
module regex_capture_group_scanner_top #(
  parameter int unsigned MAX_DEPTH = rcgs_pkg::DEFAULT_MAX_DEPTH,
  parameter int unsigned MAX_LEN   = rcgs_pkg::DEFAULT_MAX_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcgs_in_if.sink    in_i,
  rcgs_out_if.source out_o
);

  localparam int unsigned PosW     = $clog2(MAX_LEN + 1);
  localparam int unsigned BegW     = $clog2(MAX_LEN);
  localparam int unsigned CapBegW  = rcgs_pkg::CAP_BEGIN_W;
  localparam int unsigned CapEndW  = rcgs_pkg::CAP_END_W;
  localparam int unsigned ChW      = rcgs_pkg::CH_W;

  // Input register stage
  logic           in_valid_q;
  logic [ChW-1:0] in_ch_q;
  logic           in_start_q;

  // Scan state
  logic [PosW-1:0] pos_q, pos_c, pos_inc;
  logic            ovf_q, ovf_d;

  // Result register stage
  logic               out_valid_q;
  logic               out_found_q, out_found_d;
  logic [CapBegW-1:0] out_beg_q, out_beg_d;
  logic [CapEndW-1:0] out_end_q, out_end_d;
  logic               out_ovf_q;

  logic                advance, fire, take, len_over, in_ready;
  rcgs_pkg::ev_t       ev;
  rcgs_pkg::stk_res_t  stk_res;
  logic [BegW-1:0]     stk_begin;

  // Move a registered byte forward whenever the result slot is free or
  // being drained; accept a new byte whenever the input slot moves too.
  assign advance  = !out_valid_q || out_o.ready;
  assign fire     = in_valid_q && advance;
  assign in_ready = !in_valid_q || advance;
  assign in_i.ready = in_ready;

  // A pattern start clears the position before this byte is placed
  assign pos_c    = in_start_q ? '0 : pos_q;
  assign pos_inc  = pos_c + PosW'(1);
  assign len_over = (pos_c >= PosW'(MAX_LEN));
  assign take     = fire && !len_over;

  rcgs_mode_tracker u_mode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (take),
    .restart_i (in_start_q),
    .ch_i      (in_ch_q),
    .ev_o      (ev)
  );

  rcgs_group_stack #(
    .MAX_DEPTH (MAX_DEPTH),
    .BegW      (BegW)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .restart_i   (in_start_q),
    .ch_i        (in_ch_q),
    .ev_i        (ev),
    .pos_i       (BegW'(pos_c)),
    .res_o       (stk_res),
    .cap_begin_o (stk_begin)
  );

  always_comb begin
    ovf_d = (in_start_q ? 1'b0 : ovf_q) | len_over | (!len_over && stk_res.push_full);
    out_found_d = !len_over && stk_res.found;
    // report zero positions when no capturing group closed
    out_beg_d = out_found_d ? CapBegW'(stk_begin) : '0;
    out_end_d = out_found_d ? CapEndW'(pos_inc)   : '0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (take) begin
        pos_q <= pos_inc;
      end
      if (fire) begin
        ovf_q <= ovf_d;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_ch_q    <= in_i.ch;
      in_start_q <= in_i.pattern_start;
    end
    if (fire) begin
      out_found_q <= out_found_d;
      out_beg_q   <= out_beg_d;
      out_end_q   <= out_end_d;
      out_ovf_q   <= ovf_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.found     = out_found_q;
  assign out_o.cap_begin = out_beg_q;
  assign out_o.cap_end   = out_end_q;
  assign out_o.overflow  = out_ovf_q;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the capture group scanner.
// ----------------------------------------------------------------------------
// Pattern bytes go in on a valid/ready stream. A behavioral scanner in this
// bench tracks the same modes and open-group stack and predicts one result
// per accepted byte. The monitor compares every result beat field by field
// with the oldest prediction. Stimulus runs in this order:
//   - a table of hand-picked bytes, some with the expected result typed in
//   - a nesting run that goes past the stack depth while the output is held
//     off for a long stretch
//   - a few hundred bytes of random patterns, mostly well formed, some
//     pure noise
//   - a stretch of random patterns streamed with no idling on either side
// ----------------------------------------------------------------------------
module tb_top;
  import rcgs_pkg::*;

  localparam int unsigned MAX_DEPTH    = DEFAULT_MAX_DEPTH;
  localparam int unsigned MAX_LEN      = DEFAULT_MAX_LEN;
  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned RAND_BYTES   = 240;
  localparam int unsigned STEADY_BYTES = 80;
  localparam int unsigned HOLD_CYCLES  = 64;

  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOW_Z = 8'h7A;

  // Bytes that steer the scanner, plus the byte extremes
  localparam logic [CH_W-1:0] STEER_CH [14] = '{
    CH_LPAREN, CH_RPAREN, CH_LBRACKET, CH_RBRACKET, CH_BSLASH, CH_QMARK,
    CH_STAR, CH_LT, CH_P, CH_APOS, CH_Q, CH_E, 8'h00, 8'hFF
  };

  typedef struct packed {
    logic                   found;
    logic [CAP_BEGIN_W-1:0] cap_begin;
    logic [CAP_END_W-1:0]   cap_end;
    logic                   overflow;
  } scan_res_t;

  typedef struct packed {
    logic [CAP_BEGIN_W-1:0] open_pos;
    logic [2:0][CH_W-1:0]   tail;     // first bytes after the '('
    logic [1:0]             n_tail;
  } open_grp_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            start;
    logic            typed;    // want holds the expected result
    scan_res_t       want;
  } stim_row_t;

  localparam scan_res_t NO_GROUP = '0;

  // Hand-picked bytes. First pattern runs straight out of reset (no start),
  // second pattern is opened with a start beat.
  localparam int unsigned N_DIRECTED = 34;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{CH_RPAREN,   1'b0, 1'b1, NO_GROUP},                  // unmatched close
    '{CH_LPAREN,   1'b0, 1'b1, NO_GROUP},
    '{CH_RPAREN,   1'b0, 1'b1, '{1'b1, 12'd1, 13'd3, 1'b0}}, // empty group
    '{CH_LPAREN,   1'b0, 1'b0, NO_GROUP},
    '{CH_QMARK,    1'b0, 1'b0, NO_GROUP},
    '{CH_P,        1'b0, 1'b0, NO_GROUP},
    '{CH_LT,       1'b0, 1'b0, NO_GROUP},
    '{CH_RPAREN,   1'b0, 1'b1, '{1'b1, 12'd3, 13'd8, 1'b0}}, // ?P< named
    '{CH_LPAREN,   1'b0, 1'b0, NO_GROUP},
    '{CH_STAR,     1'b0, 1'b0, NO_GROUP},
    '{CH_RPAREN,   1'b0, 1'b1, NO_GROUP},                  // '*' group
    '{CH_LBRACKET, 1'b0, 1'b0, NO_GROUP},
    '{CH_BSLASH,   1'b0, 1'b0, NO_GROUP},                  // inert in class
    '{CH_LPAREN,   1'b0, 1'b0, NO_GROUP},
    '{CH_RBRACKET, 1'b0, 1'b0, NO_GROUP},
    '{CH_BSLASH,   1'b0, 1'b0, NO_GROUP},
    '{CH_LPAREN,   1'b0, 1'b0, NO_GROUP},                  // escaped paren
    '{CH_BSLASH,   1'b0, 1'b0, NO_GROUP},
    '{CH_Q,        1'b0, 1'b0, NO_GROUP},
    '{CH_RPAREN,   1'b0, 1'b0, NO_GROUP},                  // hidden by \Q
    '{CH_BSLASH,   1'b0, 1'b0, NO_GROUP},
    '{CH_E,        1'b0, 1'b0, NO_GROUP},
    '{CH_LPAREN,   1'b1, 1'b1, NO_GROUP},
    '{CH_QMARK,    1'b0, 1'b0, NO_GROUP},
    '{CH_APOS,     1'b0, 1'b0, NO_GROUP},
    '{8'hFF,       1'b0, 1'b0, NO_GROUP},
    '{CH_RPAREN,   1'b0, 1'b1, '{1'b1, 12'd0, 13'd5, 1'b0}}, // ?' named
    '{CH_LPAREN,   1'b0, 1'b0, NO_GROUP},
    '{CH_QMARK,    1'b0, 1'b0, NO_GROUP},
    '{CH_LT,       1'b0, 1'b0, NO_GROUP},
    '{CH_RPAREN,   1'b0, 1'b1, '{1'b1, 12'd5, 13'd9, 1'b0}}, // ?< named
    '{CH_LPAREN,   1'b0, 1'b0, NO_GROUP},
    '{8'h00,       1'b0, 1'b0, NO_GROUP},                  // zero byte
    '{CH_RPAREN,   1'b0, 1'b1, '{1'b1, 12'd9, 13'd12, 1'b0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  rcgs_in_if  in_if ();
  rcgs_out_if out_if ();

  regex_capture_group_scanner_top #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_LEN   (MAX_LEN)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // --------------------------------------------------------------------------
  // Scanner state mirrored by the bench
  // --------------------------------------------------------------------------
  logic [12:0] sc_pos    = '0;
  logic        sc_class  = 1'b0;
  logic        sc_esc    = 1'b0;
  logic        sc_lit    = 1'b0;
  logic        sc_lit_bs = 1'b0;
  open_grp_t   sc_grp [MAX_DEPTH];
  logic [4:0]  sc_depth  = '0;
  logic        sc_ovf    = 1'b0;

  scan_res_t       byte_results_q [$];
  logic [CH_W-1:0] pat_q [$];

  logic        steady_flow = 1'b0;  // no idling on either side
  logic        hold_req    = 1'b0;  // ask the receiver for a long stall
  int unsigned n_err       = 0;
  int unsigned n_sent      = 0;
  int unsigned n_groups    = 0;
  int unsigned n_ovf_beats = 0;

  // Advance the mirrored scanner by one byte and return its result.
  function automatic scan_res_t scan_byte(input logic [CH_W-1:0] c, input logic start);
    scan_res_t   res;
    logic [12:0] pos;
    open_grp_t   top;
    res = '0;
    if (start) begin
      sc_pos    = '0;
      sc_class  = 1'b0;
      sc_esc    = 1'b0;
      sc_lit    = 1'b0;
      sc_lit_bs = 1'b0;
      sc_depth  = '0;
      sc_ovf    = 1'b0;
    end
    if (sc_pos >= MAX_LEN) begin
      // past the length limit: only the sticky flag moves
      sc_ovf = 1'b1;
    end else begin
      pos    = sc_pos;
      sc_pos = pos + 13'd1;
      // every open group records its first three raw bytes, in any mode
      for (int i = 0; i < MAX_DEPTH; i++) begin
        if (i < sc_depth && sc_grp[i].n_tail < 2'd3) begin
          sc_grp[i].tail[sc_grp[i].n_tail] = c;
          sc_grp[i].n_tail = sc_grp[i].n_tail + 2'd1;
        end
      end
      if (sc_class) begin
        if (c == CH_RBRACKET) sc_class = 1'b0;
      end else if (sc_esc) begin
        sc_esc = 1'b0;
        if (c == CH_Q) sc_lit = 1'b1;
      end else if (sc_lit) begin
        if (sc_lit_bs && c == CH_E) begin
          sc_lit_bs = 1'b0;
          sc_lit    = 1'b0;
        end else begin
          sc_lit_bs = (c == CH_BSLASH);
        end
      end else if (c == CH_BSLASH) begin
        sc_esc = 1'b1;
      end else if (c == CH_LBRACKET) begin
        sc_class = 1'b1;
      end else if (c == CH_LPAREN) begin
        if (sc_depth >= MAX_DEPTH) begin
          sc_ovf = 1'b1;
        end else begin
          sc_grp[sc_depth].open_pos = pos[CAP_BEGIN_W-1:0];
          sc_grp[sc_depth].tail     = '0;
          sc_grp[sc_depth].n_tail   = '0;
          sc_depth = sc_depth + 5'd1;
        end
      end else if (c == CH_RPAREN && sc_depth != 0) begin
        top = sc_grp[sc_depth - 5'd1];
        if (top.tail[0] == CH_QMARK ?
            (top.tail[1] == CH_LT || top.tail[1] == CH_APOS ||
             (top.tail[1] == CH_P && top.tail[2] == CH_LT)) :
            (top.tail[0] != CH_STAR)) begin
          res.found     = 1'b1;
          res.cap_begin = top.open_pos;
          res.cap_end   = pos + 13'd1;
        end
        sc_depth = sc_depth - 5'd1;
      end
    end
    res.overflow = sc_ovf;
    return res;
  endfunction

  // Append one byte to the pattern being built.
  function automatic void add_ch(input logic [CH_W-1:0] c);
    pat_q.insert(pat_q.size(), c);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: offer one byte, idling at random first, and record the
  // prediction once the beat is taken.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [CH_W-1:0] c, input logic start,
                           input logic typed, input scan_res_t want);
    scan_res_t pred;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.ch            <= c;
    in_if.pattern_start <= start;
    do @(posedge clk_i); while (!in_if.ready);
    pred = scan_byte(c, start);
    // typed rows stand on their own; the mirror still has to advance
    byte_results_q.insert(byte_results_q.size(), typed ? want : pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Send pat_q; the first byte opens a new pattern when fresh is set.
  task automatic send_pattern(input logic fresh);
    foreach (pat_q[i]) send_byte(pat_q[i], fresh && i == 0, 1'b0, NO_GROUP);
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (byte_results_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Build a random, mostly well formed pattern in pat_q.
  task automatic build_pattern();
    int unsigned opens;
    int unsigned n_tok;
    opens = 0;
    pat_q.delete();
    n_tok = $urandom_range(14, 3);
    repeat (n_tok) begin
      case ($urandom_range(11))
        0, 1, 2: begin
          add_ch(CH_LPAREN);
          opens++;
          // group prefix: plain, non-capturing or one of the named forms
          case ($urandom_range(7))
            0: ;
            1: begin add_ch(CH_QMARK); add_ch(CH_COLON); end
            2: begin add_ch(CH_QMARK); add_ch(CH_LT); end
            3: begin add_ch(CH_QMARK); add_ch(CH_APOS); end
            4: begin
              add_ch(CH_QMARK);
              add_ch(CH_P);
              add_ch(CH_LT);
            end
            5: begin
              add_ch(CH_QMARK);
              add_ch(CH_P);
              add_ch(STEER_CH[$urandom_range(13)]);
            end
            6: add_ch(CH_STAR);
            default: begin
              add_ch(CH_QMARK);
              add_ch(STEER_CH[$urandom_range(13)]);
            end
          endcase
        end
        3, 4: begin
          add_ch(CH_RPAREN);
          if (opens > 0) opens--;
        end
        5: begin
          add_ch(CH_LBRACKET);
          repeat ($urandom_range(3)) add_ch(STEER_CH[$urandom_range(13)]);
          add_ch(CH_RBRACKET);
        end
        6: begin
          add_ch(CH_BSLASH);
          add_ch(STEER_CH[$urandom_range(13)]);
        end
        7: begin
          add_ch(CH_BSLASH);
          add_ch(CH_Q);
          repeat ($urandom_range(4)) add_ch(STEER_CH[$urandom_range(13)]);
          if ($urandom_range(3) != 0) begin
            add_ch(CH_BSLASH);
            add_ch(CH_E);
          end
        end
        8, 9, 10: add_ch(CH_W'($urandom_range(CH_LOW_Z, CH_LOW_A)));
        default: add_ch(CH_W'($urandom_range(255)));
      endcase
    end
    // usually close what is still open
    if ($urandom_range(3) != 0) repeat (opens) add_ch(CH_RPAREN);
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready toggles at random, or holds low for a counted stall
  // --------------------------------------------------------------------------
  initial begin : drive_ready
    int unsigned hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic report_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_err++;
    end
  endtask

  // Compare every result beat with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    scan_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (out_if.found) n_groups++;
      if (out_if.overflow) n_ovf_beats++;
      if (byte_results_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %0d/%0d/%0d/%0d",
                 $time, out_if.found, out_if.cap_begin, out_if.cap_end,
                 out_if.overflow);
        n_err++;
      end else begin
        want = byte_results_q.pop_front();
        report_field("found", want.found, out_if.found);
        report_field("cap_begin", want.cap_begin, out_if.cap_begin);
        report_field("cap_end", want.cap_end, out_if.cap_end);
        report_field("overflow", want.overflow, out_if.overflow);
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, byte_results_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n_rand;
    in_if.valid         = 1'b0;
    in_if.ch            = '0;
    in_if.pattern_start = 1'b0;
    rst_ni              = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].ch, DIRECTED[i].start, DIRECTED[i].typed, DIRECTED[i].want);
    // sender pauses until the block has emptied
    wait_drain();

    // Nest past the stack depth while the receiver stalls: the block fills
    // up and has to push back on its input. The extra closes then hit an
    // empty stack.
    hold_req = 1'b1;
    pat_q.delete();
    repeat (MAX_DEPTH + 2) add_ch(CH_LPAREN);
    add_ch(CH_LOW_A);
    repeat (MAX_DEPTH + 2) add_ch(CH_RPAREN);
    send_pattern(1'b1);
    wait_drain();

    // Random patterns; some are pure noise, some continue the last pattern
    n_rand = 0;
    while (n_rand < RAND_BYTES) begin
      if ($urandom_range(99) < 15) begin
        pat_q.delete();
        repeat ($urandom_range(12, 1)) add_ch(CH_W'($urandom_range(255)));
      end else begin
        build_pattern();
      end
      send_pattern($urandom_range(9) != 0);
      n_rand += pat_q.size();
    end
    wait_drain();

    // Stream fresh patterns with no idling on either side
    steady_flow = 1'b1;
    n_rand = 0;
    while (n_rand < STEADY_BYTES) begin
      build_pattern();
      send_pattern(1'b1);
      n_rand += pat_q.size();
    end
    wait_drain();
    steady_flow = 1'b0;

    // A fresh pattern starts from a clear overflow flag
    build_pattern();
    send_pattern(1'b1);
    wait_drain();

    repeat (8) @(posedge clk_i);
    if (byte_results_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, byte_results_q.size());
      n_err++;
    end

    $display("Run covered %0d pattern bytes, %0d capturing groups reported,", n_sent, n_groups);
    $display("%0d beats under overflow, %0d mismatches.", n_ovf_beats, n_err);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
